// ----- src/ucd_pkg.sv -----
// Package for the universal comb delay block.
// Holds the register map, reset values, the configuration struct and the sequencer states.
// It depends on nothing else.
package ucd_pkg;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_DELAY_LENGTH     = 2'd0;
   localparam logic [1:0] REG_BLEND_GAIN       = 2'd1;
   localparam logic [1:0] REG_FEEDBACK_GAIN    = 2'd2;
   localparam logic [1:0] REG_FEEDFORWARD_GAIN = 2'd3;

   localparam int DELAY_LENGTH_W = 15;
   localparam int GAIN_W         = 16;
   localparam int FRAC_BITS      = 14;
   localparam int ROUND_HALF     = 8192;

   localparam logic [DELAY_LENGTH_W-1:0] DELAY_LENGTH_RESET     = 15'd0;
   localparam logic signed [GAIN_W-1:0]  BLEND_GAIN_RESET       = 16'sd16384;
   localparam logic signed [GAIN_W-1:0]  FEEDBACK_GAIN_RESET    = 16'sd8192;
   localparam logic signed [GAIN_W-1:0]  FEEDFORWARD_GAIN_RESET = 16'sd4096;

   typedef struct packed {
      logic [DELAY_LENGTH_W-1:0] delay_length;
      logic signed [GAIN_W-1:0]  blend_gain;
      logic signed [GAIN_W-1:0]  feedback_gain;
      logic signed [GAIN_W-1:0]  feedforward_gain;
   } ucd_cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_FEED,
      ST_MIX,
      ST_OUT
   } ucd_state_type;

endpackage

// ----- src/universal_comb_delay.sv -----
// Universal comb filter with an echo of up to DELAY_DEPTH samples. Each sample x reads the
// sample d stored delay_length samples earlier, stores h = sat(x + feedback_gain*d) and
// returns y = sat(feedforward_gain*d + blend_gain*h), with Q2.14 gains rounded to nearest.
// A delay length of zero passes samples straight through. One sample is in work at a time:
// its result is loaded into the output register from state OUT, reached through the delay
// memory read, two multiply stages and the write-back (straight from IDLE in pass-through),
// and the next sample can be accepted in the cycle after. Entries never written since reset read
// as zero through a write-position wrap flag, so the block is ready right after reset. A
// result waiting in the output register does not block the next sample from entering.
// Depends on ucd_pkg, ucd_csr, ucd_core and ucd_ram.
module universal_comb_delay #(
   parameter int DELAY_DEPTH = 16384,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] req_tdata,  // sample_in
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,  // sample_out
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [ucd_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [ucd_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [ucd_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);

   localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

   ucd_pkg::ucd_cfg_type          cfg;
   logic signed [SAMPLE_BITS-1:0] req_sample;
   logic signed [SAMPLE_BITS-1:0] rsp_sample;

   assign req_sample = signed'(req_tdata[SAMPLE_BITS-1:0]);
   assign rsp_tdata  = TDATA_W'(unsigned'(rsp_sample));

   ucd_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready),
      .cfg        (cfg)
   );

   ucd_core #(
      .DELAY_DEPTH(DELAY_DEPTH),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_sample(req_sample),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_sample(rsp_sample)
   );

endmodule

// ----- src/ucd_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// Width and depth are parameters; it depends on no package.
module ucd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/ucd_csr.sv -----
// Register file of the universal comb delay block, written and read over an APB-style port.
// Uses the register map and configuration struct of ucd_pkg.
module ucd_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ucd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [ucd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ucd_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output ucd_pkg::ucd_cfg_type            cfg
);

   ucd_pkg::ucd_cfg_type cfg_ff;
   ucd_pkg::ucd_cfg_type cfg_in;
   logic                 write_en;
   logic [1:0]           reg_index;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel & csr_penable & csr_pwrite;
   assign reg_index  = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_index)
            ucd_pkg::REG_DELAY_LENGTH: begin
               cfg_in.delay_length = csr_pwdata[ucd_pkg::DELAY_LENGTH_W-1:0];
            end
            ucd_pkg::REG_BLEND_GAIN: begin
               cfg_in.blend_gain = csr_pwdata[ucd_pkg::GAIN_W-1:0];
            end
            ucd_pkg::REG_FEEDBACK_GAIN: begin
               cfg_in.feedback_gain = csr_pwdata[ucd_pkg::GAIN_W-1:0];
            end
            ucd_pkg::REG_FEEDFORWARD_GAIN: begin
               cfg_in.feedforward_gain = csr_pwdata[ucd_pkg::GAIN_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         ucd_pkg::REG_DELAY_LENGTH: begin
            csr_prdata = ucd_pkg::CSR_DATA_W'(cfg_ff.delay_length);
         end
         ucd_pkg::REG_BLEND_GAIN: begin
            csr_prdata = ucd_pkg::CSR_DATA_W'(unsigned'(cfg_ff.blend_gain));
         end
         ucd_pkg::REG_FEEDBACK_GAIN: begin
            csr_prdata = ucd_pkg::CSR_DATA_W'(unsigned'(cfg_ff.feedback_gain));
         end
         ucd_pkg::REG_FEEDFORWARD_GAIN: begin
            csr_prdata = ucd_pkg::CSR_DATA_W'(unsigned'(cfg_ff.feedforward_gain));
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delay_length     <= ucd_pkg::DELAY_LENGTH_RESET;
         cfg_ff.blend_gain       <= ucd_pkg::BLEND_GAIN_RESET;
         cfg_ff.feedback_gain    <= ucd_pkg::FEEDBACK_GAIN_RESET;
         cfg_ff.feedforward_gain <= ucd_pkg::FEEDFORWARD_GAIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- src/ucd_core.sv -----
// Sequencer and arithmetic of the universal comb delay block around the delay memory.
// Uses ucd_pkg for the configuration struct and states, and instantiates ucd_ram.
module ucd_core #(
   parameter int DELAY_DEPTH = 16384,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ucd_pkg::ucd_cfg_type          cfg,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample
);

   localparam int AW     = $clog2(DELAY_DEPTH);
   localparam int CW     = ((AW > ucd_pkg::DELAY_LENGTH_W) ? AW : ucd_pkg::DELAY_LENGTH_W) + 2;
   localparam int PW     = SAMPLE_BITS + ucd_pkg::GAIN_W;
   localparam int ACC_W  = SAMPLE_BITS + 18;
   localparam logic signed [ACC_W-1:0] SAT_MAX =
      ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(ucd_pkg::ROUND_HALF);
   localparam logic [CW-1:0]           DEPTH_C = CW'(DELAY_DEPTH);
   localparam logic [AW-1:0]           LAST_WP = AW'(DELAY_DEPTH - 1);

   ucd_pkg::ucd_state_type state_ff, state_in;

   logic [AW-1:0]                 wp_ff, wp_in;
   logic                          wrapped_ff, wrapped_in;
   logic                          bypass_ff, bypass_in;
   logic                          rd_valid_ff, rd_valid_in;
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic signed [SAMPLE_BITS-1:0] d_ff, d_in;
   logic signed [SAMPLE_BITS-1:0] h_ff, h_in;
   logic signed [PW-1:0]          pfb_ff, pfb_in;
   logic signed [PW-1:0]          pff_ff, pff_in;
   logic signed [PW-1:0]          pbl_ff, pbl_in;
   logic                          out_valid_ff, out_valid_in;
   logic signed [SAMPLE_BITS-1:0] out_ff, out_in;

   logic [CW-1:0]                 len_c, n_c, wp_c, rd_c;
   logic                          rd_en, wr_en;
   logic [SAMPLE_BITS-1:0]        rd_data;
   logic signed [SAMPLE_BITS-1:0] d_mem;
   logic signed [ACC_W-1:0]       acc_h, acc_y, rnd_h, rnd_y;
   logic signed [SAMPLE_BITS-1:0] h_sat, y_sat;
   logic                          accept, deliver;

   assign len_c = CW'(cfg.delay_length);
   assign wp_c  = CW'(wp_ff);
   assign n_c   = (len_c > DEPTH_C) ? DEPTH_C : len_c;
   assign rd_c  = (wp_c >= n_c) ? (wp_c - n_c) : (wp_c + DEPTH_C - n_c);

   assign d_mem = rd_valid_ff ? signed'(rd_data) : '0;

   assign acc_h = (ACC_W'(x_ff) <<< ucd_pkg::FRAC_BITS) + ACC_W'(pfb_ff) + HALF;
   assign rnd_h = acc_h >>> ucd_pkg::FRAC_BITS;
   assign h_sat = (rnd_h > SAT_MAX) ? SAT_MAX[SAMPLE_BITS-1:0] :
                  (rnd_h < SAT_MIN) ? SAT_MIN[SAMPLE_BITS-1:0] : rnd_h[SAMPLE_BITS-1:0];

   assign acc_y = ACC_W'(pff_ff) + ACC_W'(pbl_ff) + HALF;
   assign rnd_y = acc_y >>> ucd_pkg::FRAC_BITS;
   assign y_sat = (rnd_y > SAT_MAX) ? SAT_MAX[SAMPLE_BITS-1:0] :
                  (rnd_y < SAT_MIN) ? SAT_MIN[SAMPLE_BITS-1:0] : rnd_y[SAMPLE_BITS-1:0];

   assign req_tready = (state_ff == ucd_pkg::ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign rd_en      = accept & (cfg.delay_length != '0);
   assign wr_en      = (state_ff == ucd_pkg::ST_FEED);
   assign deliver    = (state_ff == ucd_pkg::ST_OUT) & (~out_valid_ff | rsp_tready);

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      wrapped_in   = wrapped_ff;
      bypass_in    = bypass_ff;
      rd_valid_in  = rd_valid_ff;
      x_in         = x_ff;
      d_in         = d_ff;
      h_in         = h_ff;
      pfb_in       = pfb_ff;
      pff_in       = pff_ff;
      pbl_in       = pbl_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      case (state_ff)
         ucd_pkg::ST_IDLE: begin
            if (accept) begin
               x_in        = req_sample;
               bypass_in   = (cfg.delay_length == '0);
               rd_valid_in = wrapped_ff | (rd_c < wp_c);
               state_in    = (cfg.delay_length == '0) ? ucd_pkg::ST_OUT : ucd_pkg::ST_FETCH;
            end
         end
         ucd_pkg::ST_FETCH: begin
            d_in     = d_mem;
            pfb_in   = cfg.feedback_gain * d_mem;
            state_in = ucd_pkg::ST_FEED;
         end
         ucd_pkg::ST_FEED: begin
            h_in = h_sat;
            if (wp_ff == LAST_WP) begin
               wp_in      = '0;
               wrapped_in = 1'b1;
            end else begin
               wp_in = wp_ff + AW'(1);
            end
            state_in = ucd_pkg::ST_MIX;
         end
         ucd_pkg::ST_MIX: begin
            pff_in   = cfg.feedforward_gain * d_ff;
            pbl_in   = cfg.blend_gain * h_ff;
            state_in = ucd_pkg::ST_OUT;
         end
         ucd_pkg::ST_OUT: begin
            if (deliver) begin
               out_in       = bypass_ff ? x_ff : y_sat;
               out_valid_in = 1'b1;
               state_in     = ucd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ucd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ucd_pkg::ST_IDLE;
         wp_ff        <= '0;
         wrapped_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         wrapped_ff   <= wrapped_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bypass_ff   <= bypass_in;
      rd_valid_ff <= rd_valid_in;
      x_ff        <= x_in;
      d_ff        <= d_in;
      h_ff        <= h_in;
      pfb_ff      <= pfb_in;
      pff_ff      <= pff_in;
      pbl_ff      <= pbl_in;
      out_ff      <= out_in;
   end

   ucd_ram #(
      .WIDTH(SAMPLE_BITS),
      .DEPTH(DELAY_DEPTH)
   ) u_delay_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wp_ff),
      .wr_data(h_sat),
      .rd_en  (rd_en),
      .rd_addr(rd_c[AW-1:0]),
      .rd_data(rd_data)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_sample = out_ff;

endmodule

// ----- verif/universal_comb_delay_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for universal_comb_delay: streams samples through the comb filter
// under many register settings and checks each result against an in-bench echo-line model.
// Depends on ucd_pkg and the universal_comb_delay RTL.
module universal_comb_delay_tb;

   localparam int DELAY_DEPTH = 16384;
   localparam int SAMPLE_BITS = 24;
   localparam longint SAMPLE_MAX = 64'sd8388607;
   localparam longint SAMPLE_MIN = -64'sd8388608;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [SAMPLE_BITS-1:0]          req_tdata = '0;  // sample_in
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [SAMPLE_BITS-1:0]          rsp_tdata;  // sample_out
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [ucd_pkg::CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [ucd_pkg::CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [ucd_pkg::CSR_DATA_W-1:0]  csr_prdata;
   logic                            csr_pready;

   universal_comb_delay #(
      .DELAY_DEPTH(DELAY_DEPTH),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Filter state and register copy used for prediction.
   longint echo_line [DELAY_DEPTH];
   int     echo_pos = 0;
   int     cfg_delay = int'(ucd_pkg::DELAY_LENGTH_RESET);
   longint cfg_blend = longint'(ucd_pkg::BLEND_GAIN_RESET);
   longint cfg_feedback = longint'(ucd_pkg::FEEDBACK_GAIN_RESET);
   longint cfg_feedforward = longint'(ucd_pkg::FEEDFORWARD_GAIN_RESET);

   logic [SAMPLE_BITS-1:0] sample_backlog [$];
   logic [SAMPLE_BITS-1:0] expected_out [$];
   logic [SAMPLE_BITS-1:0] wanted_sample;

   int samples_sent = 0;
   int samples_checked = 0;
   int settings_applied = 0;
   int failures = 0;
   int reports = 0;
   int burst_left = 0;
   int gap_left = 0;
   int stall_count = 0;
   int stall_mode = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint clamp_sample(input longint value);
      if (value > SAMPLE_MAX) return SAMPLE_MAX;
      if (value < SAMPLE_MIN) return SAMPLE_MIN;
      return value;
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] comb_response(
      input logic [SAMPLE_BITS-1:0] x_bits);
      longint x;
      longint delayed;
      longint held;
      longint mixed;
      int     span;
      int     read_pos;
      x = longint'($signed(x_bits));
      if (cfg_delay == 0) return x_bits;
      span = (cfg_delay > DELAY_DEPTH) ? DELAY_DEPTH : cfg_delay;
      read_pos = (echo_pos >= span) ? echo_pos - span : echo_pos + DELAY_DEPTH - span;
      delayed = echo_line[read_pos];
      held = clamp_sample((x * 16384 + cfg_feedback * delayed + 8192)
                          >>> ucd_pkg::FRAC_BITS);
      mixed = clamp_sample((cfg_feedforward * delayed + cfg_blend * held + 8192)
                           >>> ucd_pkg::FRAC_BITS);
      echo_line[echo_pos] = held;
      echo_pos = (echo_pos + 1) % DELAY_DEPTH;
      return mixed[SAMPLE_BITS-1:0];
   endfunction

   // Each register write is followed by a read-back of the same register.
   task automatic csr_write(input logic [1:0] index, input logic [31:0] value, input int keep_bits);
      logic [31:0] keep_mask;
      keep_mask = (32'd1 << keep_bits) - 32'd1;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if ((csr_prdata & keep_mask) !== (value & keep_mask)) begin
         failures++;
         if (reports < 10)
            $display("Register %0d read back %h, expected %h.", index,
                     csr_prdata & keep_mask, value & keep_mask);
         reports++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic apply_setting(input int delay, input int blend, input int feedback,
                                input int feedforward);
      csr_write(ucd_pkg::REG_DELAY_LENGTH, 32'(delay), ucd_pkg::DELAY_LENGTH_W);
      cfg_delay = delay;
      csr_write(ucd_pkg::REG_BLEND_GAIN, 32'(blend), ucd_pkg::GAIN_W);
      cfg_blend = longint'(blend);
      csr_write(ucd_pkg::REG_FEEDBACK_GAIN, 32'(feedback), ucd_pkg::GAIN_W);
      cfg_feedback = longint'(feedback);
      csr_write(ucd_pkg::REG_FEEDFORWARD_GAIN, 32'(feedforward), ucd_pkg::GAIN_W);
      cfg_feedforward = longint'(feedforward);
      settings_applied++;
   endtask

   task automatic settle();
      while (sample_backlog.size() != 0 || req_tvalid || expected_out.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic queue_corners();
      sample_backlog.push_back(24'h7FFFFF);
      sample_backlog.push_back(24'h800000);
      sample_backlog.push_back(24'h000000);
      sample_backlog.push_back(24'hFFFFFF);
   endtask

   function automatic int pick_gain();
      case ($urandom_range(0, 7))
         0: return -32768;
         1: return 32767;
         2: return 0;
         3, 4: return int'($signed(16'($urandom)));
         default: return int'($urandom_range(0, 16384)) - 8192;
      endcase
   endfunction

   // Sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_out.push_back(comb_response(req_tdata));
            samples_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (sample_backlog.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tdata <= sample_backlog.pop_front();
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, ($urandom_range(0, 3) == 0) ? 40 : 6);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: rsp_tready follows one of four stall modes, redrawn at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         stall_count++;
         if (stall_count % 97 == 0) stall_mode = $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= ($urandom_range(0, 7) == 0);
            default: rsp_tready <= ((stall_count % 16) < 10);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_out.size() == 0) begin
            failures++;
            if (reports < 10) $display("Unexpected result transfer: %h.", rsp_tdata);
            reports++;
         end else begin
            wanted_sample = expected_out.pop_front();
            samples_checked++;
            if (rsp_tdata !== wanted_sample) begin
               failures++;
               if (reports < 10)
                  $display("Result %0d mismatch: expected %h, got %h.", samples_checked,
                           wanted_sample, rsp_tdata);
               reports++;
            end
         end
      end
   end

   initial begin
      int delay;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset values give bypass; then short, saturating and full-depth delays.
      queue_corners();
      settle();
      apply_setting(1, int'(ucd_pkg::BLEND_GAIN_RESET), int'(ucd_pkg::FEEDBACK_GAIN_RESET),
                    int'(ucd_pkg::FEEDFORWARD_GAIN_RESET));
      queue_corners();
      settle();
      apply_setting(3, 32767, 32767, 32767);
      queue_corners();
      settle();
      apply_setting(2, -32768, -32768, -32768);
      queue_corners();
      settle();
      apply_setting(DELAY_DEPTH, 16384, -8192, 12000);
      queue_corners();
      settle();
      apply_setting(32767, -16384, 20000, -32768);
      queue_corners();
      settle();

      // Random settings; the echo line is not cleared between them.
      for (int phase = 0; phase < 12; phase++) begin
         case ($urandom_range(0, 9))
            0: delay = 0;
            1: delay = $urandom_range(DELAY_DEPTH, 32767);
            2: delay = $urandom_range(65, DELAY_DEPTH - 1);
            3, 4: delay = $urandom_range(9, 64);
            default: delay = $urandom_range(1, 8);
         endcase
         apply_setting(delay, pick_gain(), pick_gain(), pick_gain());
         for (int k = 0; k < 85; k++) begin
            case ($urandom_range(0, 7))
               0: sample_backlog.push_back($urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000);
               1: sample_backlog.push_back(24'($urandom_range(0, 512)) - 24'd256);
               default: sample_backlog.push_back(24'($urandom));
            endcase
         end
         settle();
      end

      repeat (20) @(posedge clock);
      $display("Sent %0d samples under %0d register settings, bypass to beyond-depth delays.",
               samples_sent, settings_applied);
      $display("Checked %0d results; %0d failures.", samples_checked, failures);
      if (failures == 0 && expected_out.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Timeout with %0d results still outstanding.", expected_out.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- sim.f -----
src/ucd_pkg.sv
src/ucd_ram.sv
src/ucd_csr.sv
src/ucd_core.sv
src/universal_comb_delay.sv
verif/universal_comb_delay_tb.sv
